// ===== rtl/core/jdh_pkg.sv =====
package jdh_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int TICK_BITS     = 12;
    localparam int CFG_DATA_BITS = (TICK_BITS > SAMPLE_BITS) ? TICK_BITS : SAMPLE_BITS;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF_TICKS   = 2'd3;

    // Reset values
    localparam logic [SAMPLE_BITS-1:0] RST_LOW_THRESHOLD   = SAMPLE_BITS'(350);
    localparam logic [SAMPLE_BITS-1:0] RST_HIGH_THRESHOLD  = SAMPLE_BITS'(700);
    localparam logic [SAMPLE_BITS-1:0] RST_LIGHT_THRESHOLD = SAMPLE_BITS'(800);
    localparam logic [TICK_BITS-1:0]   RST_HOLDOFF_TICKS   = TICK_BITS'(2404);

    // Commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Converter channels
    localparam logic [1:0] CH_X       = 2'd0;
    localparam logic [1:0] CH_Y       = 2'd1;
    localparam logic [1:0] CH_LIGHT   = 2'd2;
    localparam logic [1:0] CH_INVALID = 2'd3;

    // Directions, also the bit positions of the hold-off flags
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low_threshold;
        logic [SAMPLE_BITS-1:0] high_threshold;
        logic [SAMPLE_BITS-1:0] light_threshold;
        logic [TICK_BITS-1:0]   holdoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] direction;
        logic       sleep_flag;
        logic [1:0] next_channel;
    } t_result;

endpackage

// ===== rtl/core/jdh_cfg_regs.sv =====
module jdh_cfg_regs
    import jdh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold   <= RST_LOW_THRESHOLD;
            r_cfg.high_threshold  <= RST_HIGH_THRESHOLD;
            r_cfg.light_threshold <= RST_LIGHT_THRESHOLD;
            r_cfg.holdoff_ticks   <= RST_HOLDOFF_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_THRESHOLD:   r_cfg.low_threshold   <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_HIGH_THRESHOLD:  r_cfg.high_threshold  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_LIGHT_THRESHOLD: r_cfg.light_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_HOLDOFF_TICKS:   r_cfg.holdoff_ticks   <= i_cfg_data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/jdh_core.sv =====
module jdh_core
    import jdh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [1:0]             i_command,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_cfg                   i_cfg,
    output t_result                o_result
);

    logic [SAMPLE_BITS-1:0] r_axis_x, n_axis_x;
    logic [SAMPLE_BITS-1:0] r_axis_y, n_axis_y;
    logic [3:0]             r_flags, n_flags;
    logic [TICK_BITS-1:0]   r_elapsed, n_elapsed;
    logic [1:0]             r_channel, n_channel;
    logic                   r_sleep, n_sleep;

    logic [3:0] flags_vis;
    logic [3:0] beyond;
    logic [3:0] want;
    logic       is_axis;
    logic       emit;
    logic [1:0] dir;

    always_comb begin
        n_axis_x  = r_axis_x;
        n_axis_y  = r_axis_y;
        n_flags   = r_flags;
        n_elapsed = r_elapsed;
        n_channel = r_channel;
        n_sleep   = r_sleep;
        is_axis   = 1'b0;

        case (i_command)
            CMD_SAMPLE: begin
                case (r_channel)
                    CH_X: begin
                        n_axis_x  = i_sample;
                        n_channel = CH_Y;
                        is_axis   = 1'b1;
                    end
                    CH_Y: begin
                        n_axis_y  = i_sample;
                        n_channel = CH_LIGHT;
                        is_axis   = 1'b1;
                    end
                    default: begin
                        // light channel; the unreachable fourth code acts the same
                        if (i_sample <= i_cfg.light_threshold) begin
                            n_sleep = 1'b1;
                        end
                        n_channel = CH_X;
                    end
                endcase
            end
            CMD_TICK: begin
                if (r_elapsed != {TICK_BITS{1'b1}}) begin
                    n_elapsed = r_elapsed + TICK_BITS'(1);
                end
            end
            CMD_CLEAR: n_sleep = 1'b0;
            default: ;
        endcase

        // Drop all hold-off flags once the hold-off time has run out
        flags_vis = (r_elapsed > i_cfg.holdoff_ticks) ? 4'b0000 : r_flags;

        beyond[DIR_LEFT]  = n_axis_x < i_cfg.low_threshold;
        beyond[DIR_RIGHT] = n_axis_x > i_cfg.high_threshold;
        beyond[DIR_UP]    = n_axis_y < i_cfg.low_threshold;
        beyond[DIR_DOWN]  = n_axis_y > i_cfg.high_threshold;
        want = beyond & ~flags_vis;

        emit = is_axis && (want != 4'b0000);
        if (want[DIR_LEFT]) begin
            dir = DIR_LEFT;
        end else if (want[DIR_RIGHT]) begin
            dir = DIR_RIGHT;
        end else if (want[DIR_UP]) begin
            dir = DIR_UP;
        end else begin
            dir = DIR_DOWN;
        end

        if (is_axis) begin
            n_flags = flags_vis;
            if (emit) begin
                n_flags[dir] = 1'b1;
                n_elapsed    = '0;
            end
        end

        o_result.event_valid  = emit;
        o_result.direction    = emit ? dir : DIR_LEFT;
        o_result.sleep_flag   = n_sleep;
        o_result.next_channel = n_channel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x  <= '0;
            r_axis_y  <= '0;
            r_flags   <= '0;
            r_elapsed <= '0;
            r_channel <= CH_X;
            r_sleep   <= 1'b0;
        end else if (i_fire) begin
            r_axis_x  <= n_axis_x;
            r_axis_y  <= n_axis_y;
            r_flags   <= n_flags;
            r_elapsed <= n_elapsed;
            r_channel <= n_channel;
            r_sleep   <= n_sleep;
        end
    end

    a_event_restarts_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.event_valid |=> r_elapsed == '0)
        else $error("tick counter not restarted after an event");

    a_event_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.event_valid |=> r_flags[$past(o_result.direction)])
        else $error("hold-off flag not set after an event");

    a_no_event_off_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_command != CMD_SAMPLE || r_channel == CH_LIGHT
                   || r_channel == CH_INVALID) |-> !o_result.event_valid)
        else $error("event raised by a non-axis item");

    a_channel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_channel != CH_INVALID)
        else $error("channel rotation left its range");

endmodule

// ===== rtl/core/joystick_direction_holdoff_top.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// input    | in        | i_in_valid / o_in_stall| i_command, i_sample
// result   | out       | o_out_valid/i_out_stall| o_event_valid, o_direction,
//          |           |                        | o_sleep_flag, o_next_channel
// config   | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One word in, one word out, one word per cycle sustained while not stalled;
// each word passes the input register, then the decision logic feeding the
// result register. The rate is set by the state update in jdh_core: each word
// reads the axis, flag and tick state left by the previous one.
// Reset (i_rst_n low, synchronous) empties both stages and restores defaults.
// A stall on the result side holds the result register and backs up into the
// input register; o_in_stall rises only when both stages are full.
module joystick_direction_holdoff_top
    import jdh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_command,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_event_valid,
    output logic [1:0]               o_direction,
    output logic                     o_sleep_flag,
    output logic [1:0]               o_next_channel,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic                   r_in_vld;
    logic [1:0]             r_command;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_vld;
    t_result                r_result;

    logic out_free;
    logic in_take;
    logic fire;

    // Result register can load when empty or being taken this cycle
    assign out_free = !r_out_vld || !i_out_stall;
    // Input register can load when empty or advancing into the result stage
    assign in_take  = !r_in_vld || out_free;
    assign fire     = r_in_vld && out_free;

    assign o_in_stall = !in_take;

    jdh_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    jdh_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_command (r_command),
        .i_sample  (r_sample),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Input stage: capture a word whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_command <= i_command;
            r_sample  <= i_sample;
        end
    end

    // Result stage: advance on a free slot, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_valid  = r_result.event_valid;
    assign o_direction    = r_result.direction;
    assign o_sleep_flag   = r_result.sleep_flag;
    assign o_next_channel = r_result.next_channel;

endmodule
